/* design/wes_pkg.sv */
// Shared types and constants for the 2D wave-equation stencil block.
package wes_pkg;

    // Fixed field widths
    localparam int SAMPLE_W    = 24;
    localparam int VEL_W       = 16;
    localparam int COEF_W      = 17;
    localparam int SIZE_W      = 11;
    localparam int IDX_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    // Line-buffer word: {vel_above, older_above, cur_two_above, cur_above}
    localparam int LINE_W = 2 * VEL_W + 3 * SAMPLE_W - VEL_W;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 11'd1024;
    localparam logic [COEF_W-1:0] COEF_RST      = 17'd2007;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS = 2'd0,
        CFG_GRID_COLS = 2'd1,
        CFG_COEF_X    = 2'd2,
        CFG_COEF_Y    = 2'd3
    } wes_cfg_idx_t;

    // One stencil job: operands and tags of the cell one row above the input
    typedef struct packed {
        logic [IDX_W-1:0]    row_a;      // row of the updated cell
        logic [IDX_W-1:0]    row_b;      // row of the flushed last-row cell
        logic [IDX_W-1:0]    col;
        logic                interior;
        logic                two_out;    // input is on the last row
        logic                last_col;
        logic [SAMPLE_W-1:0] p;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] below;
        logic [SAMPLE_W-1:0] two_above;
        logic [SAMPLE_W-1:0] old_above;
        logic [SAMPLE_W-1:0] old_in;
        logic [VEL_W-1:0]    vel;
    } wes_job_t;

endpackage

/* design/wes_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wes_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/wes_front.sv */
// Front end: accepts cells, tracks position, runs line buffers, issues stencil jobs.
module wes_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [wes_pkg::SIZE_W-1:0]     grid_rows,
    input  logic [wes_pkg::SIZE_W-1:0]     grid_cols,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: cur_sample[23:0], older_sample[47:24], vel_squared[63:48]
    input  logic [wes_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [wes_pkg::QCNT_W-1:0]     q_count,
    output logic                           q_push,
    output wes_pkg::wes_job_t              q_job
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int RLW   = (ROW_W + 1 > wes_pkg::SIZE_W) ? ROW_W + 1 : wes_pkg::SIZE_W;
    localparam int CLW   = (COL_W + 1 > wes_pkg::SIZE_W) ? COL_W + 1 : wes_pkg::SIZE_W;
    localparam int SW    = wes_pkg::SAMPLE_W;
    localparam int VW    = wes_pkg::VEL_W;

    // Position of the next input cell
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] col_plus;

    // Clamped sizes
    logic [RLW-1:0] rows_ext, rows_cl, rows_m1, row_ext;
    logic [CLW-1:0] cols_ext, cols_cl, cols_m1, col_ext;

    logic accept;
    logic last_row0, last_col0, interior0, has_out0;
    logic [31:0] row32, rowm1_32, col32;
    logic [wes_pkg::QCNT_W:0] queue_load;

    // Stage 1 registers (line-buffer read data lands here)
    logic                      f1_valid_reg;
    logic [SW-1:0]             f1_cur_reg, f1_old_reg;
    logic [VW-1:0]             f1_vel_reg;
    logic [COL_W-1:0]          f1_col_reg;
    logic [wes_pkg::IDX_W-1:0] f1_row_a_reg, f1_row_b_reg, f1_col10_reg;
    logic                      f1_last_row_reg, f1_last_col_reg;
    logic                      f1_interior_reg, f1_has_out_reg;

    logic [SW-1:0]               left_reg;
    logic [wes_pkg::LINE_W-1:0]  line_rd;
    logic [SW-1:0]               right_rd;

    // Hold off input when the queue could not absorb the item in flight
    assign queue_load = {1'b0, q_count} + {{wes_pkg::QCNT_W{1'b0}}, f1_valid_reg};
    assign s_tready   = queue_load < (wes_pkg::QCNT_W + 1)'(wes_pkg::QUEUE_DEPTH);
    assign accept     = s_tvalid && s_tready;

    // Size clamping and cell classification
    always_comb begin
        rows_ext = RLW'(grid_rows);
        cols_ext = CLW'(grid_cols);
        if (rows_ext < RLW'(3)) begin
            rows_cl = RLW'(3);
        end else if (rows_ext > RLW'(MAX_ROWS)) begin
            rows_cl = RLW'(MAX_ROWS);
        end else begin
            rows_cl = rows_ext;
        end
        if (cols_ext < CLW'(3)) begin
            cols_cl = CLW'(3);
        end else if (cols_ext > CLW'(MAX_COLS)) begin
            cols_cl = CLW'(MAX_COLS);
        end else begin
            cols_cl = cols_ext;
        end
        rows_m1   = rows_cl - RLW'(1);
        cols_m1   = cols_cl - CLW'(1);
        row_ext   = RLW'(row_reg);
        col_ext   = CLW'(col_reg);
        last_row0 = row_ext >= rows_m1;
        last_col0 = col_ext >= cols_m1;
        has_out0  = row_reg != '0;
        // updated cell is row-1: interior when 1 <= row-1 < rows-1
        interior0 = (row_ext >= RLW'(2)) && (row_ext < rows_cl) &&
                    (col_reg != '0) && !last_col0;
        row32     = 32'(row_reg);
        rowm1_32  = row32 - 32'd1;
        col32     = 32'(col_reg);
    end

    // Right-neighbor address, wrapped at the buffer end
    assign col_plus = (col_reg == COL_W'(MAX_COLS - 1)) ? '0 : col_reg + COL_W'(1);

    // Raster position counters
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept) begin
            if (last_col0) begin
                col_next = '0;
                row_next = last_row0 ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            f1_valid_reg <= 1'b0;
            left_reg     <= '0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            f1_valid_reg <= accept;
            if (f1_valid_reg) begin
                left_reg <= line_rd[SW-1:0];
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_cur_reg      <= s_tdata[SW-1:0];
            f1_old_reg      <= s_tdata[2*SW-1:SW];
            f1_vel_reg      <= s_tdata[2*SW+VW-1:2*SW];
            f1_col_reg      <= col_reg;
            f1_row_a_reg    <= rowm1_32[wes_pkg::IDX_W-1:0];
            f1_row_b_reg    <= row32[wes_pkg::IDX_W-1:0];
            f1_col10_reg    <= col32[wes_pkg::IDX_W-1:0];
            f1_last_row_reg <= last_row0;
            f1_last_col_reg <= last_col0;
            f1_interior_reg <= interior0;
            f1_has_out_reg  <= has_out0;
        end
    end

    // Line buffers: current/two-above/older/velocity word, plus a copy of the
    // current row read one column ahead for the right neighbor
    wes_ram #(
        .WIDTH (wes_pkg::LINE_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (f1_valid_reg),
        .wr_addr (f1_col_reg),
        .wr_data ({f1_vel_reg, f1_old_reg, line_rd[SW-1:0], f1_cur_reg}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    wes_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_COLS)
    ) u_right_ram (
        .aclk    (aclk),
        .wr_en   (f1_valid_reg),
        .wr_addr (f1_col_reg),
        .wr_data (f1_cur_reg),
        .rd_en   (accept),
        .rd_addr (col_plus),
        .rd_data (right_rd)
    );

    // Job issue; first-row cells produce nothing and are dropped here
    assign q_push = f1_valid_reg && f1_has_out_reg;

    always_comb begin
        q_job.row_a     = f1_row_a_reg;
        q_job.row_b     = f1_row_b_reg;
        q_job.col       = f1_col10_reg;
        q_job.interior  = f1_interior_reg;
        q_job.two_out   = f1_last_row_reg;
        q_job.last_col  = f1_last_col_reg;
        q_job.p         = line_rd[SW-1:0];
        q_job.left      = left_reg;
        q_job.right     = right_rd;
        q_job.below     = f1_cur_reg;
        q_job.two_above = line_rd[2*SW-1:SW];
        q_job.old_above = line_rd[3*SW-1:2*SW];
        q_job.vel       = line_rd[3*SW+VW-1:3*SW];
        q_job.old_in    = f1_old_reg;
    end

endmodule

/* design/wes_queue.sv */
// Short job queue decoupling the front end from the arithmetic back end.
module wes_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  wes_pkg::wes_job_t          push_job,
    input  logic                       pop,
    output wes_pkg::wes_job_t          head_job,
    output logic                       empty,
    output logic [wes_pkg::QCNT_W-1:0] count
);

    wes_pkg::wes_job_t slot_reg [wes_pkg::QUEUE_DEPTH];

    logic [wes_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wes_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wes_pkg::QCNT_W-1:0] count_reg, count_next;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + wes_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + wes_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + wes_pkg::QCNT_W'(push) - wes_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = slot_reg[rd_ptr_reg];
    assign empty    = count_reg == '0;
    assign count    = count_reg;

endmodule

/* design/wes_back.sv */
// Back end: stencil arithmetic pipeline and result emission (one or two per job).
module wes_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [wes_pkg::COEF_W-1:0]      coef_x,
    input  logic [wes_pkg::COEF_W-1:0]      coef_y,
    input  logic                            q_empty,
    input  wes_pkg::wes_job_t               q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: out_row[9:0], out_col[19:10], new_sample[43:20], zero pad[47:44]
    output logic [wes_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,  // end_of_grid
    output logic                            m_tuser   // last_of_item
);

    localparam int STAGES = 5;
    localparam logic [60:0] ROUND_BIAS = 61'd134217728;  // 2^27

    logic pipe_en, fire;
    logic [STAGES-1:0] vld_reg, vld_next;
    wes_pkg::wes_job_t job_reg [STAGES];

    // Arithmetic stage values
    logic signed [25:0] lapx, lapy, lapx_reg, lapy_reg;
    logic signed [17:0] cx_s, cy_s;
    logic signed [43:0] px, py, px_reg, py_reg;
    logic        [43:0] acc, acc_reg;
    logic        [21:0] acc_lo;
    logic signed [21:0] acc_hi;
    logic signed [16:0] vel_s;
    logic        [37:0] plo, plo_reg;
    logic signed [38:0] phi, phi_reg;
    logic        [60:0] prod;
    logic        [32:0] s_val, s_reg;
    logic        [34:0] upd_sum;
    logic        [23:0] upd_sat, first_val;

    // Output and pending second result
    logic        m_valid_reg, m_valid_next;
    logic [9:0]  m_row_reg, m_row_next, m_col_reg, m_col_next;
    logic [23:0] m_val_reg, m_val_next;
    logic        m_item_reg, m_item_next, m_eog_reg, m_eog_next;
    logic        sec_pend_reg, sec_pend_next;
    logic [9:0]  sec_row_reg, sec_row_next;
    logic [23:0] sec_val_reg, sec_val_next;
    logic        sec_eog_reg, sec_eog_next;

    // Whole pipeline moves together when the output register can take a result
    assign fire     = m_valid_reg && m_tready;
    assign pipe_en  = !sec_pend_reg && (!m_valid_reg || m_tready);
    assign q_pop    = pipe_en && !q_empty;
    assign vld_next = pipe_en ? {vld_reg[STAGES-2:0], !q_empty} : vld_reg;

    // Stage 1: Laplacian terms, exact in 26 bits
    assign lapx = {{2{q_head.right[23]}}, q_head.right} + {{2{q_head.left[23]}}, q_head.left}
                - {q_head.p[23], q_head.p, 1'b0};
    assign lapy = {{2{q_head.below[23]}}, q_head.below}
                + {{2{q_head.two_above[23]}}, q_head.two_above}
                - {q_head.p[23], q_head.p, 1'b0};

    // Stage 2: coefficient products
    assign cx_s = {1'b0, coef_x};
    assign cy_s = {1'b0, coef_y};
    assign px   = cx_s * lapx_reg;
    assign py   = cy_s * lapy_reg;

    // Stage 3: sum of the two terms, Q.32
    assign acc = px_reg + py_reg;

    // Stage 4: velocity product split into two partial products
    assign acc_lo = acc_reg[21:0];
    assign acc_hi = acc_reg[43:22];
    assign vel_s  = {1'b0, job_reg[2].vel};
    assign plo    = {16'b0, acc_lo} * {22'b0, job_reg[2].vel};
    assign phi    = acc_hi * vel_s;

    // Stage 5: recombine and round Q.44 to Q.16, ties upward
    assign prod  = {phi_reg, 22'b0} + {23'b0, plo_reg} + ROUND_BIAS;
    assign s_val = prod[60:28];

    // Final update with saturation to 24 bits
    assign upd_sum = {{10{job_reg[4].p[23]}}, job_reg[4].p, 1'b0}
                   + {{2{s_reg[32]}}, s_reg}
                   - {{11{job_reg[4].old_above[23]}}, job_reg[4].old_above};
    always_comb begin
        if (upd_sum[34:23] == '0 || upd_sum[34:23] == '1) begin
            upd_sat = upd_sum[23:0];
        end else if (upd_sum[34]) begin
            upd_sat = 24'h800000;
        end else begin
            upd_sat = 24'h7FFFFF;
        end
    end
    assign first_val = job_reg[4].interior ? upd_sat : job_reg[4].old_above;

    // Output register: first result from the pipe, second from the pending slot
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        m_val_next    = m_val_reg;
        m_item_next   = m_item_reg;
        m_eog_next    = m_eog_reg;
        sec_pend_next = sec_pend_reg;
        sec_row_next  = sec_row_reg;
        sec_val_next  = sec_val_reg;
        sec_eog_next  = sec_eog_reg;
        if (pipe_en) begin
            if (vld_reg[STAGES-1]) begin
                m_valid_next  = 1'b1;
                m_row_next    = job_reg[4].row_a;
                m_col_next    = job_reg[4].col;
                m_val_next    = first_val;
                m_item_next   = !job_reg[4].two_out;
                m_eog_next    = 1'b0;
                sec_pend_next = job_reg[4].two_out;
                sec_row_next  = job_reg[4].row_b;
                sec_val_next  = job_reg[4].old_in;
                sec_eog_next  = job_reg[4].last_col;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (fire) begin
            m_row_next    = sec_row_reg;
            m_val_next    = sec_val_reg;
            m_item_next   = 1'b1;
            m_eog_next    = sec_eog_reg;
            sec_pend_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
            sec_pend_reg <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            m_valid_reg  <= m_valid_next;
            sec_pend_reg <= sec_pend_next;
        end
    end

    // Pipeline and output payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            job_reg[0] <= q_head;
            for (int i = 1; i < STAGES; i++) begin
                job_reg[i] <= job_reg[i-1];
            end
            lapx_reg <= lapx;
            lapy_reg <= lapy;
            px_reg   <= px;
            py_reg   <= py;
            acc_reg  <= acc;
            plo_reg  <= plo;
            phi_reg  <= phi;
            s_reg    <= s_val;
        end
        m_row_reg   <= m_row_next;
        m_col_reg   <= m_col_next;
        m_val_reg   <= m_val_next;
        m_item_reg  <= m_item_next;
        m_eog_reg   <= m_eog_next;
        sec_row_reg <= sec_row_next;
        sec_val_reg <= sec_val_next;
        sec_eog_reg <= sec_eog_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_val_reg, m_col_reg, m_row_reg};
    assign m_tlast  = m_eog_reg;
    assign m_tuser  = m_item_reg;

endmodule

/* design/wave_equation_stencil_2d.sv */
// Top level: 2D acoustic wave step, 5-point stencil over a raster-order cell stream.
// Throughput: one cell per cycle unless the output stalls; on the last grid row two results
//   share the single output register, and the pipe waits until the second one is taken.
// Reset: position counters, job queue and output clear; registers return to their
//   reset values; line buffers are not cleared and need no clearing pass.
module wave_equation_stencil_2d #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [wes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wes_pkg::COEF_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: cur_sample[23:0], older_sample[47:24], vel_squared[63:48]
    input  logic [wes_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: out_row[9:0], out_col[19:10], new_sample[43:20], zero pad[47:44]
    output logic [wes_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,  // end_of_grid
    output logic                            m_tuser   // last_of_item
);

    logic [wes_pkg::SIZE_W-1:0] grid_rows_reg, grid_cols_reg;
    logic [wes_pkg::COEF_W-1:0] coef_x_reg, coef_y_reg;

    logic                       q_push, q_pop, q_empty;
    logic [wes_pkg::QCNT_W-1:0] q_count;
    wes_pkg::wes_job_t          push_job, head_job;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= wes_pkg::GRID_SIZE_RST;
            grid_cols_reg <= wes_pkg::GRID_SIZE_RST;
            coef_x_reg    <= wes_pkg::COEF_RST;
            coef_y_reg    <= wes_pkg::COEF_RST;
        end else if (cfg_wr_en) begin
            case (wes_pkg::wes_cfg_idx_t'(cfg_index))
                wes_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata[wes_pkg::SIZE_W-1:0];
                wes_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_wdata[wes_pkg::SIZE_W-1:0];
                wes_pkg::CFG_COEF_X:    coef_x_reg    <= cfg_wdata;
                wes_pkg::CFG_COEF_Y:    coef_y_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    wes_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grid_rows (grid_rows_reg),
        .grid_cols (grid_cols_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    wes_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .count    (q_count)
    );

    wes_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .coef_x   (coef_x_reg),
        .coef_y   (coef_y_reg),
        .q_empty  (q_empty),
        .q_head   (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
